/* hw/rtl/signed_int32_sorter_assert.svh */
// Assertion macros shared by the checker files of the sorter.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SIGNED_INT32_SORTER_ASSERT_SVH
`define SIGNED_INT32_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SI32S_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SI32S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/si32s_pkg.sv */
// Shared constants and types of the signed 32-bit sorter.
// No dependencies; the other files of the block, but for the assertion header, refer to it by scoped names.
package si32s_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int VALUE_W   = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Commands from the controller to the insertion chain.
	typedef struct packed {
		logic insert;
		logic shift;
	} cmd_t;

	// Status from the insertion chain back to the controller.
	typedef struct packed {
		logic full;
		logic head_last;
	} stat_t;

endpackage

/* hw/rtl/si32s_if.sv */
// Valid/ready channel interfaces for the sorter's input items and results.
// Depends on si32s_pkg for the value type.
interface si32s_in_if;
	logic             valid;
	logic             ready;
	si32s_pkg::value_t value;
	logic             last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface si32s_out_if;
	logic             valid;
	logic             ready;
	si32s_pkg::value_t sorted_value;
	logic             last_out;
	logic             overflow;

	modport source (output valid, output sorted_value, output last_out, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input last_out, input overflow,
		output ready);
endinterface

/* hw/rtl/si32s_datapath.sv */
// Insertion chain of the sorter: a row of cells kept in ascending signed order.
// Depends on si32s_pkg for the capacity, value type and command/status structs.
module si32s_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  si32s_pkg::cmd_t   cmd,
	input  si32s_pkg::value_t ins_value,
	output si32s_pkg::stat_t  stat,
	output si32s_pkg::value_t head_value
);

	localparam int N = si32s_pkg::MAX_ITEMS;

	si32s_pkg::value_t val_q [N];
	logic [N-1:0]      vld_q;

	// g marks cells that are empty or hold a value greater than the new one.
	// It is low for a prefix of the chain and high for the rest.
	logic [N-1:0] g;
	logic [N-1:0] g_prev;
	logic [N-1:0] v_prev;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			g[i] = !vld_q[i] || (val_q[i] > ins_value);
		end
		g_prev[0] = 1'b0;
		v_prev[0] = 1'b1;
		for (int i = 1; i < N; i++) begin
			g_prev[i] = g[i-1];
			v_prev[i] = vld_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.insert) begin
			vld_q <= vld_q | v_prev;
		end else if (cmd.shift) begin
			vld_q <= {1'b0, vld_q[N-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < N; i++) begin
				if (g[i] && !g_prev[i]) begin
					val_q[i] <= ins_value;
				end else if (g[i] && i > 0) begin
					val_q[i] <= val_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < N - 1; i++) begin
				val_q[i] <= val_q[i+1];
			end
		end
	end

	assign stat.full      = vld_q[N-1];
	assign stat.head_last = vld_q[0] && !vld_q[1];
	assign head_value     = val_q[0];

endmodule

/* hw/rtl/si32s_ctrl.sv */
// Controller of the sorter: loads a set, then drains it from the head of the chain.
// Depends on si32s_pkg for the command and status structs.
module si32s_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             overflow,
	output si32s_pkg::cmd_t  cmd,
	input  si32s_pkg::stat_t stat
);

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   ovf_q;
	logic   in_xfer;
	logic   out_xfer;

	assign in_xfer  = in_valid && in_ready_q;
	assign out_xfer = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (stat.full) begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q     <= ST_EMIT;
							in_ready_q  <= 1'b0;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_xfer && stat.head_last) begin
						state_q     <= ST_LOAD;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b0;
						ovf_q       <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_LOAD;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
					ovf_q       <= 1'b0;
				end
			endcase
		end
	end

	// A value that finds the chain full is dropped and only noted in the flag.
	assign cmd.insert = in_xfer && !stat.full;
	assign cmd.shift  = out_xfer;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign overflow  = ovf_q;

endmodule

/* hw/rtl/signed_int32_sorter.sv */
// Sorter of signed 32-bit integers, ascending order, up to MAX_ITEMS values a set.
// Channel "items" (sink) takes value and last; channel "results" (source) gives
// sorted_value, last_out and overflow. A transfer happens when valid and ready are
// both high at a rising edge of clk.
// Loading: one value is taken each cycle while ready is high. Each value is put in
// place in an insertion chain of MAX_ITEMS cells at once. Values arriving with the
// chain full are dropped and raise overflow on every result of that set.
// Emission: the cycle after the transfer with last high, results become valid; one
// result leaves the head of the chain each cycle that results.ready is high.
// Items are not taken while a set is being emitted; the next set may start in the
// cycle after the transfer of the result with last_out high.
// A stalled receiver simply holds the current result; nothing is lost.
// Reset (arst_n low) empties the chain at once and clears overflow; the block is
// ready for a new set straight after.
// Depends on si32s_pkg, si32s_if, si32s_ctrl and si32s_datapath.
module signed_int32_sorter (
	input  logic        clk,
	input  logic        arst_n,
	si32s_in_if.sink    items,
	si32s_out_if.source results
);

	si32s_pkg::cmd_t   cmd;
	si32s_pkg::stat_t  stat;
	si32s_pkg::value_t head_value;

	si32s_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.overflow  (results.overflow),
		.cmd       (cmd),
		.stat      (stat)
	);

	si32s_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.ins_value  (items.value),
		.stat       (stat),
		.head_value (head_value)
	);

	assign results.sorted_value = head_value;
	assign results.last_out     = stat.head_last;

endmodule

/* hw/rtl/si32s_checker.sv */
// Port-level checker for the sorter, attached to the top level by a bind.
// Depends on signed_int32_sorter_assert.svh and si32s_pkg.
`include "signed_int32_sorter_assert.svh"

module si32s_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input si32s_pkg::value_t sorted_value,
	input logic              last_out,
	input logic              overflow
);

	logic              out_xfer;
	logic              in_set_q;
	si32s_pkg::value_t prev_q;
	logic              prev_ovf_q;

	assign out_xfer = out_valid && out_ready;

	// Remembers the previous result of the set being emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_set_q <= 1'b0;
		end else if (out_xfer) begin
			in_set_q <= !last_out;
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			prev_q     <= sorted_value;
			prev_ovf_q <= overflow;
		end
	end

	`SI32S_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
		out_valid && $stable(sorted_value) && $stable(last_out) && $stable(overflow),
		"stalled result changed")
	`SI32S_ASSERT_NOW(a_no_load_during_emit, out_valid, !in_ready,
		"items accepted while a set is being emitted")
	`SI32S_ASSERT_NOW(a_ascending, out_xfer && in_set_q, sorted_value >= prev_q,
		"results not in ascending signed order")
	`SI32S_ASSERT_NOW(a_overflow_steady, out_xfer && in_set_q, overflow == prev_ovf_q,
		"overflow changed within a set")
	`SI32S_ASSERT_NEXT(a_set_ends, out_xfer && last_out, !out_valid,
		"results still valid after the final transfer of a set")

endmodule

bind signed_int32_sorter si32s_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (items.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.sorted_value (results.sorted_value),
	.last_out     (results.last_out),
	.overflow     (results.overflow)
);
